### rtl/hsc_pkg.sv
package hsc_pkg;

   localparam int DATA_W = 64;
   localparam int CODE_W = 71;
   localparam int HIGH_W = CODE_W - DATA_W;
   localparam int SYN_W  = 7;
   localparam int SEL_W  = 3;
   localparam int MAX_DATA_BITS = 64;
   localparam int MAX_CODE_BITS = 71;

   // register indexes on the csr port
   localparam logic CSR_DIRECTION    = 1'b0;
   localparam logic CSR_WIDTH_SELECT = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_CLEAN     = 2'd0,
      STATUS_CORRECTED = 2'd1,
      STATUS_OUT_RANGE = 2'd2
   } status_type;

   // codeword length for a width index; index seven acts as six
   function automatic logic [SYN_W-1:0] code_len(input logic [SEL_W-1:0] sel);
      logic [SYN_W-1:0] n;
      unique case (sel)
         3'd0:    n = 7'd12;
         3'd1:    n = 7'd17;
         3'd2:    n = 7'd21;
         3'd3:    n = 7'd29;
         3'd4:    n = 7'd38;
         3'd5:    n = 7'd54;
         default: n = 7'd71;
      endcase
      if (n > SYN_W'(MAX_CODE_BITS)) begin
         n = SYN_W'(MAX_CODE_BITS);
      end
      return n;
   endfunction

   function automatic logic [SYN_W-1:0] data_len(input logic [SEL_W-1:0] sel);
      logic [SYN_W-1:0] d;
      unique case (sel)
         3'd0:    d = 7'd8;
         3'd1:    d = 7'd12;
         3'd2:    d = 7'd16;
         3'd3:    d = 7'd24;
         3'd4:    d = 7'd32;
         3'd5:    d = 7'd48;
         default: d = 7'd64;
      endcase
      if (d > SYN_W'(MAX_DATA_BITS)) begin
         d = SYN_W'(MAX_DATA_BITS);
      end
      return d;
   endfunction

   function automatic logic [DATA_W-1:0] data_mask(input logic [SEL_W-1:0] sel);
      logic [SYN_W-1:0] d;
      d = data_len(sel);
      return {DATA_W{1'b1}} >> (SYN_W'(DATA_W) - d);
   endfunction

   function automatic logic [CODE_W-1:0] code_mask(input logic [SEL_W-1:0] sel);
      logic [SYN_W-1:0] n;
      n = code_len(sel);
      return {CODE_W{1'b1}} >> (SYN_W'(CODE_W) - n);
   endfunction

   // number of parity positions at or below position p
   function automatic int pow_count(input int p);
      int c;
      c = 0;
      for (int i = 0; i < SYN_W; i++) begin
         if ((1 << i) <= p) begin
            c++;
         end
      end
      return c;
   endfunction

   function automatic bit is_pow2(input int p);
      return (p & (p - 1)) == 0;
   endfunction

   // positions (one-based) whose number has bit i set
   function automatic logic [CODE_W-1:0] cover_mask(input int i);
      logic [CODE_W-1:0] m;
      for (int p = 1; p <= CODE_W; p++) begin
         m[p-1] = ((p >> i) & 1) != 0;
      end
      return m;
   endfunction

endpackage

### rtl/hsc_encoder.sv
module hsc_encoder (
   input  logic [hsc_pkg::DATA_W-1:0] data,
   input  logic [hsc_pkg::SEL_W-1:0]  width_select,
   output logic [hsc_pkg::CODE_W-1:0] codeword
);

   logic [hsc_pkg::DATA_W-1:0] data_m;
   logic [hsc_pkg::CODE_W-1:0] spread;
   logic [hsc_pkg::SYN_W-1:0]  parity;

   assign data_m = data & hsc_pkg::data_mask(width_select);

   // data bits go to the non-power-of-two positions in ascending order
   for (genvar p = 1; p <= hsc_pkg::CODE_W; p++) begin : g_spread
      if (hsc_pkg::is_pow2(p)) begin : g_par
         assign spread[p-1] = 1'b0;
      end else begin : g_dat
         localparam int K = p - 1 - hsc_pkg::pow_count(p);
         assign spread[p-1] = data_m[K];
      end
   end

   for (genvar i = 0; i < hsc_pkg::SYN_W; i++) begin : g_parity
      localparam logic [hsc_pkg::CODE_W-1:0] COVER = hsc_pkg::cover_mask(i);
      assign parity[i] = ^(spread & COVER);
   end

   // bits past the codeword are zero, so their parity is zero as well
   always_comb begin
      codeword = spread;
      for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
         codeword[(1 << i) - 1] = parity[i];
      end
   end

endmodule

### rtl/hsc_decoder.sv
module hsc_decoder (
   input  logic [hsc_pkg::CODE_W-1:0] codeword,
   input  logic [hsc_pkg::SEL_W-1:0]  width_select,
   output logic [hsc_pkg::DATA_W-1:0] data,
   output logic [hsc_pkg::SYN_W-1:0]  syndrome,
   output hsc_pkg::status_type        status
);

   logic [hsc_pkg::CODE_W-1:0] cw_m;
   logic [hsc_pkg::CODE_W-1:0] flip;
   logic [hsc_pkg::CODE_W-1:0] fixed;
   logic [hsc_pkg::DATA_W-1:0] data_raw;
   logic [hsc_pkg::SYN_W-1:0]  n;
   logic                       in_range;

   assign n    = hsc_pkg::code_len(width_select);
   assign cw_m = codeword & hsc_pkg::code_mask(width_select);

   for (genvar i = 0; i < hsc_pkg::SYN_W; i++) begin : g_syn
      localparam logic [hsc_pkg::CODE_W-1:0] COVER = hsc_pkg::cover_mask(i);
      assign syndrome[i] = ^(cw_m & COVER);
   end

   assign in_range = (syndrome != '0) && (syndrome <= n);

   for (genvar p = 1; p <= hsc_pkg::CODE_W; p++) begin : g_flip
      assign flip[p-1] = in_range && (syndrome == hsc_pkg::SYN_W'(p));
   end

   assign fixed = cw_m ^ flip;

   for (genvar p = 1; p <= hsc_pkg::CODE_W; p++) begin : g_strip
      if (!hsc_pkg::is_pow2(p)) begin : g_dat
         localparam int K = p - 1 - hsc_pkg::pow_count(p);
         assign data_raw[K] = fixed[p-1];
      end
   end

   assign data = data_raw & hsc_pkg::data_mask(width_select);

   always_comb begin
      if (syndrome == '0) begin
         status = hsc_pkg::STATUS_CLEAN;
      end else if (in_range) begin
         status = hsc_pkg::STATUS_CORRECTED;
      end else begin
         status = hsc_pkg::STATUS_OUT_RANGE;
      end
   end

endmodule

### rtl/hamming_sec_codec_unit.sv
// Hamming single-error-correcting codec. Each transaction carries one word:
// on encode (direction 0) a data word of 8..64 bits, chosen by width_select,
// comes back as a 12..71 bit codeword with even parity at positions 1, 2, 4,
// .. 64; on decode (direction 1) a codeword comes back as corrected data with
// the syndrome and a status (clean, corrected, or syndrome past the codeword,
// in which case nothing is flipped). Two register stages: the request register
// and the response register, with the XOR trees, correction and bit strip
// between them. A transaction is accepted every cycle unless the response
// side stalls; an accepted request is loaded into the request register, then
// into the response register, where rsp_valid shows its response. Ready backs
// up combinationally from rsp_ready through both stages. Write csr registers
// only while no transaction is in flight.
module hamming_sec_codec_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hsc_pkg::DATA_W-1:0]        req_word_low,
   input  logic [hsc_pkg::HIGH_W-1:0]        req_word_high,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hsc_pkg::DATA_W-1:0]        rsp_result_low,
   output logic [hsc_pkg::HIGH_W-1:0]        rsp_result_high,
   output logic [hsc_pkg::SYN_W-1:0]         rsp_syndrome,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_wen,
   input  logic                              csr_index,
   input  logic [hsc_pkg::SEL_W-1:0]         csr_wdata
);

   // csr
   logic                       direction_ff;
   logic [hsc_pkg::SEL_W-1:0]  width_select_ff;

   // request stage
   logic                       req_valid_ff;
   logic [hsc_pkg::CODE_W-1:0] word_ff;

   // response stage
   logic                       rsp_valid_ff;
   logic [hsc_pkg::CODE_W-1:0] result_ff;
   logic [hsc_pkg::CODE_W-1:0] result_in;
   logic [hsc_pkg::SYN_W-1:0]  syndrome_ff;
   logic [hsc_pkg::SYN_W-1:0]  syndrome_in;
   hsc_pkg::status_type        status_ff;
   hsc_pkg::status_type        status_in;

   logic                       rsp_load;
   logic                       req_load;

   logic [hsc_pkg::CODE_W-1:0] enc_codeword;
   logic [hsc_pkg::DATA_W-1:0] dec_data;
   logic [hsc_pkg::SYN_W-1:0]  dec_syndrome;
   hsc_pkg::status_type        dec_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= hsc_pkg::DIR_ENCODE;
         width_select_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            hsc_pkg::CSR_DIRECTION:    direction_ff    <= csr_wdata[0];
            hsc_pkg::CSR_WIDTH_SELECT: width_select_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // response register frees up when empty or being drained
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign req_load  = !req_valid_ff || rsp_load;
   assign req_ready = req_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_load) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         word_ff <= {req_word_high, req_word_low};
      end
   end

   hsc_encoder u_encoder (
      .data         (word_ff[hsc_pkg::DATA_W-1:0]),
      .width_select (width_select_ff),
      .codeword     (enc_codeword)
   );

   hsc_decoder u_decoder (
      .codeword     (word_ff),
      .width_select (width_select_ff),
      .data         (dec_data),
      .syndrome     (dec_syndrome),
      .status       (dec_status)
   );

   always_comb begin
      if (direction_ff == hsc_pkg::DIR_DECODE) begin
         result_in   = {{hsc_pkg::HIGH_W{1'b0}}, dec_data};
         syndrome_in = dec_syndrome;
         status_in   = dec_status;
      end else begin
         result_in   = enc_codeword;
         syndrome_in = '0;
         status_in   = hsc_pkg::STATUS_CLEAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && req_valid_ff) begin
         result_ff   <= result_in;
         syndrome_ff <= syndrome_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_low  = result_ff[hsc_pkg::DATA_W-1:0];
   assign rsp_result_high = result_ff[hsc_pkg::CODE_W-1:hsc_pkg::DATA_W];
   assign rsp_syndrome    = syndrome_ff;
   assign rsp_status      = status_ff;

   // a nonzero syndrome always comes with a non-clean status, and back
   a_syn_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((syndrome_ff == '0) == (status_ff == hsc_pkg::STATUS_CLEAN)))
      else $error("syndrome and status disagree");

   // decoded data never spills into the high bits
   a_dec_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && direction_ff == hsc_pkg::DIR_DECODE)
         |-> (result_ff[hsc_pkg::CODE_W-1:hsc_pkg::DATA_W] == '0))
      else $error("decode result has high bits set");

   // a response appears only behind a filled request stage
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid_ff))
      else $error("response without request");

   // a held request stage is not lost while the response side stalls
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_load) |=> req_valid_ff)
      else $error("request dropped under stall");

endmodule

### sim/tb_hamming_sec_codec_unit.sv
module tb_hamming_sec_codec_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import hsc_pkg::*;

   // One expected response: codeword or corrected data plus syndrome and decode status.
   typedef struct packed {
      logic [DATA_W-1:0] low;
      logic [HIGH_W-1:0] high;
      logic [SYN_W-1:0]  syn;
      status_type        status;
   } codec_result_type;

   // Tracks the csr settings, predicts each transaction and checks responses
   // in order.
   class codec_scoreboard;
      logic                direction;
      logic [SEL_W-1:0]    width_sel;
      codec_result_type    expected_q[$];
      int                  errors;
      int                  accepted;
      int                  n_encode;
      int                  n_decode;
      int                  n_corrected;
      int                  n_out_range;

      function new();
         direction = DIR_ENCODE;
         width_sel = '0;
      endfunction

      function void set_register(logic idx, logic [SEL_W-1:0] val);
         if (idx == CSR_DIRECTION) begin
            direction = val[0];
         end else begin
            width_sel = val;
         end
      endfunction

      // width index seven behaves like six
      function int code_length();
         case (width_sel)
            3'd0:    return 12;
            3'd1:    return 17;
            3'd2:    return 21;
            3'd3:    return 29;
            3'd4:    return 38;
            3'd5:    return 54;
            default: return 71;
         endcase
      endfunction

      function bit is_check_pos(int p);
         return (p & (p - 1)) == 0;
      endfunction

      function int syndrome(logic [CODE_W-1:0] w, int n);
         int s;
         s = 0;
         for (int p = 1; p <= n; p++) begin
            if (w[p-1]) begin
               s ^= p;
            end
         end
         return s;
      endfunction

      function logic [CODE_W-1:0] encode(logic [DATA_W-1:0] data);
         logic [CODE_W-1:0] w;
         int n, k, s;
         n = code_length();
         w = '0;
         k = 0;
         for (int p = 1; p <= n; p++) begin
            if (!is_check_pos(p)) begin
               w[p-1] = data[k];
               k++;
            end
         end
         // check positions are still zero, so the syndrome gives them directly
         s = syndrome(w, n);
         for (int i = 0; i < SYN_W; i++) begin
            if (s[i] && (1 << i) <= n) begin
               w[(1 << i) - 1] = 1'b1;
            end
         end
         return w;
      endfunction

      function codec_result_type predict(logic [DATA_W-1:0] lo, logic [HIGH_W-1:0] hi);
         logic [CODE_W-1:0] w;
         logic [DATA_W-1:0] data;
         int n, k, s;
         codec_result_type r;
         r = '0;
         n = code_length();
         if (direction == DIR_ENCODE) begin
            w = encode(lo);
            r.low  = w[DATA_W-1:0];
            r.high = w[CODE_W-1:DATA_W];
         end else begin
            w = {hi, lo};
            s = syndrome(w, n);
            r.syn = s[SYN_W-1:0];
            if (s != 0 && s <= n) begin
               w[s-1] = ~w[s-1];
               r.status = STATUS_CORRECTED;
            end else if (s != 0) begin
               // points past the codeword: leave the bits alone
               r.status = STATUS_OUT_RANGE;
            end
            data = '0;
            k = 0;
            for (int p = 1; p <= n; p++) begin
               if (!is_check_pos(p)) begin
                  data[k] = w[p-1];
                  k++;
               end
            end
            r.low = data;
         end
         return r;
      endfunction

      function void note_request(logic [DATA_W-1:0] lo, logic [HIGH_W-1:0] hi);
         codec_result_type r;
         r = predict(lo, hi);
         expected_q.push_back(r);
         accepted++;
         if (direction == DIR_ENCODE) begin
            n_encode++;
         end else begin
            n_decode++;
         end
         if (r.status == STATUS_CORRECTED) begin
            n_corrected++;
         end
         if (r.status == STATUS_OUT_RANGE) begin
            n_out_range++;
         end
      endfunction

      function void check_response(logic [DATA_W-1:0] lo, logic [HIGH_W-1:0] hi,
                                   logic [SYN_W-1:0] syn, logic [1:0] st);
         codec_result_type e;
         if (expected_q.size() == 0) begin
            $error("response with no transaction outstanding: result_low %h", lo);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (lo !== e.low) begin
            $error("result_low: expected %h, got %h", e.low, lo);
            errors++;
         end
         if (hi !== e.high) begin
            $error("result_high: expected %h, got %h", e.high, hi);
            errors++;
         end
         if (syn !== e.syn) begin
            $error("syndrome: expected %0d, got %0d", e.syn, syn);
            errors++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
         end
      endfunction
   endclass

   localparam int PHASE_ITEMS  = 70;     // random transactions per csr setting
   localparam int WATCHDOG_MAX = 4000;   // cycles with no handshake or csr write
   localparam int HOLD_CYCLES  = 90;     // long receiver hold-off
   localparam int HOLD_AT      = 400;    // ... after this many requests

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [DATA_W-1:0]   req_word_low;
   logic [HIGH_W-1:0]   req_word_high;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [DATA_W-1:0]   rsp_result_low;
   logic [HIGH_W-1:0]   rsp_result_high;
   logic [SYN_W-1:0]    rsp_syndrome;
   logic [1:0]          rsp_status;
   logic                csr_wen;
   logic                csr_index;
   logic [SEL_W-1:0]    csr_wdata;

   codec_scoreboard     sb;
   bit                  idle_mode;      // random gaps and stalls enabled
   int                  setting_count;

   hamming_sec_codec_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word_low    (req_word_low),
      .req_word_high   (req_word_high),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_low  (rsp_result_low),
      .rsp_result_high (rsp_result_high),
      .rsp_syndrome    (rsp_syndrome),
      .rsp_status      (rsp_status),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [CODE_W-1:0] flip(logic [CODE_W-1:0] w, int p);
      return w ^ (CODE_W'(1) << (p - 1));
   endfunction

   // Offer one transaction and hold it until the block takes it. Inputs are
   // sampled right after the edge, so req_ready is the value the edge saw.
   task automatic send_word(input logic [DATA_W-1:0] lo, input logic [HIGH_W-1:0] hi);
      if (idle_mode && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_word_low  <= lo;
      req_word_high <= hi;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_request(lo, hi);
   endtask

   task automatic send_code(input logic [CODE_W-1:0] w);
      send_word(w[DATA_W-1:0], w[CODE_W-1:DATA_W]);
   endtask

   // Drain the pipe, then write both registers back to back. Every request
   // yields a response, so an empty queue means nothing is in flight.
   // Upper wdata bits are noise on the direction write.
   task automatic start_phase(input logic dir, input logic [SEL_W-1:0] sel, input bit idle);
      logic [SEL_W-1:0] dir_val;
      dir_val = {2'($urandom_range(0, 3)), dir};
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_DIRECTION;
      csr_wdata <= dir_val;
      @(posedge clock);
      sb.set_register(CSR_DIRECTION, dir_val);
      csr_index <= CSR_WIDTH_SELECT;
      csr_wdata <= sel;
      @(posedge clock);
      sb.set_register(CSR_WIDTH_SELECT, sel);
      csr_wen   <= 1'b0;
      idle_mode = idle;
      setting_count++;
   endtask

   // Response side: random stall bursts in idle mode, plus one long hold-off
   // so the two stages fill and req_ready drops while the sender keeps offering.
   initial begin
      int  stall_left;
      bit  held_off;
      stall_left = 0;
      held_off   = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_response(rsp_result_low, rsp_result_high, rsp_syndrome, rsp_status);
         end
         if (!held_off && sb.accepted >= HOLD_AT) begin
            held_off   = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (idle_mode && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // Watchdog: any handshake or csr write counts as progress.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wen) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= WATCHDOG_MAX) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     quiet, sb.expected_q.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [CODE_W-1:0] cw;
      logic [CODE_W-1:0] junk;
      int                order[16];
      int                pick, tmp, n, a, b;
      logic              dir;

      sb            = new();
      idle_mode     = 1'b0;
      setting_count = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word_low  = '0;
      req_word_high = '0;
      csr_wen       = 1'b0;
      csr_index     = CSR_DIRECTION;
      csr_wdata     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // encode at 64 bits: zero, all ones, word_high must be ignored,
      // alternating pattern, both end bits
      start_phase(DIR_ENCODE, 3'd6, 1'b0);
      send_word('0, '0);
      send_word('1, '0);
      send_word('1, '1);
      send_word(64'h5555_5555_5555_5555, 7'h2a);
      send_word(64'h8000_0000_0000_0001, '0);

      // encode at 8 bits: data bits above the width are ignored
      start_phase(DIR_ENCODE, 3'd0, 1'b0);
      send_word(64'hffff_ffff_ffff_ff5a, 7'h55);
      send_word(64'h0000_0000_0000_00a5, '0);

      // decode at 71 bits: clean, single flips at both ends and around the
      // word boundary, all zero, all ones, and a syndrome of 127 (past the end)
      start_phase(DIR_DECODE, 3'd6, 1'b0);
      cw = sb.encode(64'hdead_beef_0123_4567);
      send_code(cw);
      send_code(flip(cw, 1));
      send_code(flip(cw, 71));
      send_code(flip(cw, 64));
      send_code(flip(cw, 65));
      send_code('0);
      send_code('1);
      send_code(flip(flip(cw, 64), 63));

      // decode at 12 bits: syndrome 13 is past the codeword, last-bit fix,
      // junk above position 12, all ones
      start_phase(DIR_DECODE, 3'd0, 1'b0);
      cw = sb.encode(64'hc3);
      send_code(flip(flip(cw, 12), 1));
      send_code(flip(cw, 12));
      send_code(cw | ~CODE_W'(12'hfff));
      send_code('1);

      // width index seven behaves as 64-bit data
      start_phase(DIR_DECODE, 3'd7, 1'b0);
      cw = sb.encode('1);
      send_code(flip(cw, 71));
      send_code(flip(flip(cw, 64), 8));
      start_phase(DIR_ENCODE, 3'd7, 1'b0);
      send_word({$urandom, $urandom}, 7'($urandom));

      // ---- random part: every direction and width index in shuffled order ----
      for (int i = 0; i < 16; i++) begin
         order[i] = i;
      end
      for (int i = 15; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         tmp         = order[i];
         order[i]    = order[pick];
         order[pick] = tmp;
      end

      for (int ph = 0; ph < 16; ph++) begin
         dir = order[ph][3];
         // idling on most settings, never in the last two
         start_phase(dir, order[ph][2:0], (ph < 14) && ($urandom_range(0, 3) != 0));
         n = sb.code_length();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (dir == DIR_ENCODE) begin
               send_word({$urandom, $urandom}, 7'($urandom));
            end else begin
               // mostly well-formed codewords with zero to three bit errors
               cw = sb.encode({$urandom, $urandom});
               case ($urandom_range(0, 9))
                  0, 1, 2: ;
                  3, 4, 5, 6: cw = flip(cw, $urandom_range(1, n));
                  7: begin
                     a = $urandom_range(1, n);
                     b = $urandom_range(1, n - 1);
                     if (b >= a) begin
                        b++;
                     end
                     cw = flip(flip(cw, a), b);
                  end
                  8: cw = flip(flip(flip(cw, $urandom_range(1, n)),
                                    $urandom_range(1, n)), $urandom_range(1, n));
                  default: cw = {7'($urandom), $urandom, $urandom};
               endcase
               // junk past the codeword length must not matter
               if ($urandom_range(0, 1) == 1) begin
                  junk = {7'($urandom), $urandom, $urandom};
                  cw   = cw | (junk & ~((CODE_W'(1) << n) - CODE_W'(1)));
               end
               send_code(cw);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d encode and %0d decode transactions over %0d csr settings,",
               sb.n_encode, sb.n_decode, setting_count);
      $display("with %0d single-bit corrections and %0d syndromes past the codeword.",
               sb.n_corrected, sb.n_out_range);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
